// File: rtl/sdrc_pkg.sv
// Shared types, constants and the CRC7 byte update for the SD response checker.
// No dependencies; imported by every module of the block.
package sdrc_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned INDEX_W    = 6;
	localparam int unsigned CRC_W      = 7;
	localparam int unsigned S_TDATA_W  = 16;
	localparam int unsigned M_TDATA_W  = 16;

	localparam logic [CRC_W-1:0]  CRC7_POLY   = 7'h09;
	localparam int unsigned       DIR_BIT     = 6;
	localparam int unsigned       END_BIT     = 0;

	// Head flag positions within the stored header flags.
	localparam int unsigned HEAD_TRANS = 0;
	localparam int unsigned HEAD_INDEX = 1;

	// One received item, as unpacked from the slave-side stream.
	typedef struct packed {
		logic [BYTE_W-1:0]  resp_byte;
		logic               last_byte;
		logic [INDEX_W-1:0] expected_index;
		logic               check_crc;
	} item_t;

	// One result item, as packed onto the master-side stream.
	typedef struct packed {
		logic             trans_error;
		logic             end_bit_error;
		logic             index_error;
		logic             crc_error;
		logic [CRC_W-1:0] computed_crc;
	} result_t;

	// CRC7 over one byte, most significant bit first.
	function automatic logic [CRC_W-1:0] crc7_byte(
		input logic [CRC_W-1:0]  crc,
		input logic [BYTE_W-1:0] data
	);
		logic [CRC_W-1:0] r;
		logic             fb;
		r = crc;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			fb = data[i] ^ r[CRC_W-1];
			r  = {r[CRC_W-2:0], 1'b0};
			if (fb) begin
				r = r ^ CRC7_POLY;
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/sd_response_checker_core.sv
// SD command response checker, top level: stream handshakes, input and result
// registers around sdrc_resp_eval. Depends on sdrc_pkg and sdrc_resp_eval.
//
// Usage: the received response is streamed in on the s_axis channel, one byte per
// item, first byte first, with tlast on the byte that carries the CRC7 and end bit.
// The expected command index rides with every item but is taken from the first
// byte only; the CRC request is taken from the last byte only.
// Only a last byte produces a result item on the m_axis channel, carrying the
// transmission, end-bit, index and CRC error flags and the computed CRC7.
// A result item passes through the input register and then the result register
// before it is offered. Throughput: one item per cycle, unless a last byte waits
// for a full result register.
// When the receiver stalls, the result register holds its item; the input stage
// still takes and processes non-last bytes, and only a last byte that finds the
// result register full waits, which drops s_axis_tready.
// Reset clears the CRC, the header flags and all valid flags; the next byte
// accepted after reset opens a new response.
module sd_response_checker_core
	import sdrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [7:0] resp_byte, [13:8] expected_index, [14] check_crc, [15] unused
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [0] trans_error, [1] end_bit_error, [2] index_error, [3] crc_error,
	// [10:4] computed_crc, [15:11] zero
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	item_t   item_s1;
	logic    valid_s1;
	logic    advance_s1;
	logic    out_free;
	result_t res;
	result_t res_q;
	logic    m_valid_q;

	// The result register can take a new item when empty or being emptied.
	assign out_free      = !m_valid_q || m_axis_tready;
	assign advance_s1    = valid_s1 && (!item_s1.last_byte || out_free);
	assign s_axis_tready = !valid_s1 || advance_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.resp_byte      <= s_axis_tdata[BYTE_W-1:0];
			item_s1.last_byte      <= s_axis_tlast;
			item_s1.expected_index <= s_axis_tdata[BYTE_W +: INDEX_W];
			item_s1.check_crc      <= s_axis_tdata[BYTE_W + INDEX_W];
		end
	end

	sdrc_resp_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance_s1),
		.item    (item_s1),
		.res     (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= advance_s1 && item_s1.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance_s1 && item_s1.last_byte) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {
		{(M_TDATA_W - CRC_W - 4){1'b0}},
		res_q.computed_crc,
		res_q.crc_error,
		res_q.index_error,
		res_q.end_bit_error,
		res_q.trans_error
	};

endmodule

// File: rtl/sdrc_resp_eval.sv
// Per-response state of the SD response checker: running CRC7, first-byte marker
// and header flags, with the evaluation of one item. Depends on sdrc_pkg.
module sdrc_resp_eval
	import sdrc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item,
	output result_t res
);

	logic [CRC_W-1:0] crc_accum_q;
	logic             at_first_q;
	logic [1:0]       head_flags_q;
	logic [1:0]       head_now;

	// Header flags come from the byte itself when it opens a response.
	always_comb begin
		if (at_first_q) begin
			head_now[HEAD_TRANS] = item.resp_byte[DIR_BIT];
			head_now[HEAD_INDEX] = item.resp_byte[INDEX_W-1:0] != item.expected_index;
		end else begin
			head_now = head_flags_q;
		end
	end

	// Result of a last byte; only used by the top level when last_byte is set.
	always_comb begin
		res.trans_error   = head_now[HEAD_TRANS];
		res.end_bit_error = ~item.resp_byte[END_BIT];
		res.index_error   = head_now[HEAD_INDEX];
		res.crc_error     = item.check_crc &&
			(item.resp_byte[BYTE_W-1:1] != crc_accum_q);
		res.computed_crc  = crc_accum_q;
	end

	// State update: a last byte closes the response, any other byte feeds the CRC.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_accum_q  <= '0;
			at_first_q   <= 1'b1;
			head_flags_q <= '0;
		end else if (advance) begin
			if (item.last_byte) begin
				crc_accum_q  <= '0;
				at_first_q   <= 1'b1;
				head_flags_q <= '0;
			end else begin
				crc_accum_q  <= crc7_byte(crc_accum_q, item.resp_byte);
				at_first_q   <= 1'b0;
				head_flags_q <= head_now;
			end
		end
	end

endmodule

// File: rtl/sdrc_checker.sv
// Port-level assertions for the SD response checker, bound to its top level.
// Depends on sdrc_pkg and sd_response_checker_core.
module sdrc_checker
	import sdrc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata
);

	// A stalled result item stays offered.
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result item withdrawn while stalled");

	// A stalled result item keeps its payload.
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result payload changed while stalled");

	// Input back-pressure only arises from a stalled, full result register.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a stalled result");

	// Pad bits of a result item are zero.
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:CRC_W+4] == '0)
		else $error("result pad bits not zero");

endmodule

bind sd_response_checker_core sdrc_checker u_sdrc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
